@@ src/dbrb_pkg.sv @@
// Package for the double-bank overwrite ring buffer.
// Sizes, action codes, memory request type and pointer helper.
// No dependencies.
package dbrb_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned BANK_ADDR_W = ADDR_W + 1;
  localparam int unsigned MEM_WORDS   = 2 ** BANK_ADDR_W;

  typedef enum logic [2:0] {
    ACT_PUSH  = 3'd0,
    ACT_POP   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_SWAP  = 3'd3,
    ACT_CLEAR = 3'd4,
    ACT_COPY  = 3'd5
  } action_e;

  // one write port and one read port; address is {bank, index}, bank 0 = first bank
  typedef struct packed {
    logic                   we;
    logic [BANK_ADDR_W-1:0] waddr;
    logic [DATA_W-1:0]      wdata;
    logic                   re;
    logic [BANK_ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] next_idx(input logic [ADDR_W-1:0] idx);
    logic [ADDR_W-1:0] nxt;
    nxt = (idx == ADDR_W'(DEPTH - 1)) ? '0 : idx + ADDR_W'(1);
    return nxt;
  endfunction

endpackage

@@ src/dbrb_mem.sv @@
// Storage for both banks: one write and one registered read port.
// Per-word valid bits make unwritten words read as zero after reset.
// Depends on dbrb_pkg.
module dbrb_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dbrb_pkg::mem_req_t        req_i,
  output logic [dbrb_pkg::DATA_W-1:0] rdata_o
);

  logic [dbrb_pkg::DATA_W-1:0]    mem_q [dbrb_pkg::MEM_WORDS];
  logic [dbrb_pkg::MEM_WORDS-1:0] valid_q;
  logic [dbrb_pkg::DATA_W-1:0]    rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= valid_q[req_i.raddr] ? mem_q[req_i.raddr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/double_bank_overwrite_ring_buffer_core.sv @@
// Double-bank ring buffer that overwrites its oldest word when full.
// Top level; depends on dbrb_pkg and dbrb_mem.
//
// Usage
//   Slave side: one request per beat. s_axis_tuser_i carries the action
//   (push, pop, peek, swap banks, clear, copy inactive bank into active),
//   s_axis_tdata_i the word for a push. Every request gives one response
//   on the master side with read data, success flag, fill count,
//   empty/full and which bank is active.
// Flow
//   Push, swap, clear, undefined actions and failed pop/peek finish in the
//   accept cycle; the response goes into the one-entry stage and then the
//   output register, and ready stays low while the stage is full.
//   Successful pop/peek first wait in ST_READ for the registered memory read.
//   Copy walks the shared memory port once, reading word n of the inactive
//   bank while writing word n-1 of the active bank, one word per cycle.
//   No request is taken until the last response has left the stage.
// Back-pressure
//   A finished response waits in a one-entry stage and then the output
//   register; a new request is taken while the output is stalled as long
//   as the stage is free.
// Reset
//   Asynchronous, active low: empty ring, first bank active, both banks
//   read as zero until written (valid bits). No clearing pass.
module double_bank_overwrite_ring_buffer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] push_data
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o   // [31:0] read_data, [32] ok, [37:33] fill_count,
                                       // [38] is_empty, [39] is_full, [40] primary_active
);

  localparam int unsigned AW = dbrb_pkg::ADDR_W;
  localparam int unsigned CW = dbrb_pkg::CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY
  } state_e;

  typedef struct packed {
    logic [31:0] read_data;
    logic        ok;
    logic [4:0]  fill_count;
    logic        is_empty;
    logic        is_full;
    logic        primary_active;
  } result_t;

  state_e              state_q, state_d;
  logic [AW-1:0]       rptr_q, rptr_d;
  logic [AW-1:0]       wptr_q, wptr_d;
  logic [CW-1:0]       ent_q, ent_d;
  logic                prim_q, prim_d;     // 1: first bank active
  logic [CW-1:0]       cnt_q, cnt_d;       // copy sweep position
  logic                pend_valid_q, pend_valid_d;
  result_t             pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_q;

  dbrb_pkg::mem_req_t          mem_req;
  logic [dbrb_pkg::DATA_W-1:0] mem_rdata;

  logic in_acc;
  logic out_load;

  assign s_axis_tready_o = (state_q == ST_IDLE) && !pend_valid_q;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = pend_valid_q && (!out_valid_q || m_axis_tready_i);

  dbrb_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    rptr_d       = rptr_q;
    wptr_d       = wptr_q;
    ent_d        = ent_q;
    prim_d       = prim_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    mem_req      = '0;

    if (out_load) begin
      pend_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pend_d.read_data = '0;
          pend_d.ok        = 1'b0;
          pend_valid_d     = 1'b1;
          unique case (s_axis_tuser_i)
            dbrb_pkg::ACT_PUSH: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = {~prim_q, wptr_q};
              mem_req.wdata = dbrb_pkg::DATA_W'(s_axis_tdata_i);
              wptr_d        = dbrb_pkg::next_idx(wptr_q);
              if (ent_q == CW'(dbrb_pkg::DEPTH)) begin
                rptr_d = dbrb_pkg::next_idx(rptr_q);   // overwrite oldest
              end else begin
                ent_d = ent_q + CW'(1);
              end
              pend_d.ok = 1'b1;
            end
            dbrb_pkg::ACT_POP: begin
              if (ent_q != '0) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = {~prim_q, rptr_q};
                rptr_d        = dbrb_pkg::next_idx(rptr_q);
                ent_d         = ent_q - CW'(1);
                pend_d.ok     = 1'b1;
                pend_valid_d  = 1'b0;
                state_d       = ST_READ;
              end
            end
            dbrb_pkg::ACT_PEEK: begin
              if (ent_q != '0) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = {~prim_q, rptr_q};
                pend_d.ok     = 1'b1;
                pend_valid_d  = 1'b0;
                state_d       = ST_READ;
              end
            end
            dbrb_pkg::ACT_SWAP: begin
              prim_d    = ~prim_q;
              rptr_d    = '0;
              wptr_d    = '0;
              ent_d     = '0;
              pend_d.ok = 1'b1;
            end
            dbrb_pkg::ACT_CLEAR: begin
              rptr_d    = '0;
              wptr_d    = '0;
              ent_d     = '0;
              pend_d.ok = 1'b1;
            end
            dbrb_pkg::ACT_COPY: begin
              cnt_d        = '0;
              pend_d.ok    = 1'b1;
              pend_valid_d = 1'b0;
              state_d      = ST_COPY;
            end
            default: begin
              // undefined action: no change, ok low
            end
          endcase
          pend_d.fill_count     = 5'(ent_d);
          pend_d.is_empty       = (ent_d == '0);
          pend_d.is_full        = (ent_d == CW'(dbrb_pkg::DEPTH));
          pend_d.primary_active = prim_d;
        end
      end
      ST_READ: begin
        pend_d.read_data = 32'(mem_rdata);
        pend_valid_d     = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_COPY: begin
        // read inactive[n] while writing active[n-1] with last read word
        if (cnt_q < CW'(dbrb_pkg::DEPTH)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = {prim_q, AW'(cnt_q)};
        end
        if (cnt_q != '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = {~prim_q, AW'(cnt_q - CW'(1))};
          mem_req.wdata = mem_rdata;
        end
        if (cnt_q == CW'(dbrb_pkg::DEPTH)) begin
          pend_valid_d = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rptr_q       <= '0;
      wptr_q       <= '0;
      ent_q        <= '0;
      prim_q       <= 1'b1;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rptr_q       <= rptr_d;
      wptr_q       <= wptr_d;
      ent_q        <= ent_d;
      prim_q       <= prim_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= pend_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_q.primary_active, out_q.is_full, out_q.is_empty,
                            out_q.fill_count, out_q.ok, out_q.read_data};

`ifndef SYNTHESIS
  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_q <= CW'(dbrb_pkg::DEPTH))
    else $error("fill count above depth");

  a_busy_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !pend_valid_q)
    else $error("response staged while an action is still running");

  a_copy_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY && cnt_q == CW'(dbrb_pkg::DEPTH)) |=>
      (state_q == ST_IDLE && pend_valid_q))
    else $error("copy sweep did not finish with a response");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for double_bank_overwrite_ring_buffer_core.
// Directed table, then random traffic under four idle/stall phases.
// Depends on dbrb_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH  = dbrb_pkg::DEPTH;
  localparam int unsigned DATA_W = dbrb_pkg::DATA_W;
  localparam int unsigned ADDR_W = dbrb_pkg::ADDR_W;

  // action codes the block treats as undefined
  localparam logic [2:0] ACT_RSVD_6 = 3'd6;
  localparam logic [2:0] ACT_RSVD_7 = 3'd7;
  localparam int unsigned MAX_REPORTS = 10;

  // response word, lowest field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic        primary_active;
    logic        is_full;
    logic        is_empty;
    logic [4:0]  fill_count;
    logic        ok;
    logic [31:0] read_data;
  } ring_resp_t;

  typedef struct {
    logic [2:0]  act;
    logic [31:0] data;
    int unsigned reps;
    bit          typed;
    ring_resp_t  want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic [2:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;

  double_bank_overwrite_ring_buffer_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // shadow of the ring: bank 0 is the first bank
  logic [DATA_W-1:0] shadow_bank [2][DEPTH];
  logic [ADDR_W-1:0] head_idx;
  logic [ADDR_W-1:0] tail_idx;
  int unsigned       held;
  bit                first_active;

  ring_resp_t pending_responses[$];
  ring_resp_t seen_resp;
  ring_resp_t want_resp;
  stim_row_t  directed[$];

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned requests_sent;
  int unsigned responses_checked;
  int unsigned mismatches;
  int unsigned full_overwrites;
  int unsigned empty_reads;
  int unsigned copies_done;
  int unsigned swaps_done;
  int unsigned undefined_seen;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] ring_advance(logic [ADDR_W-1:0] idx);
    return ADDR_W'((int'(idx) + 1) % DEPTH);
  endfunction

  // apply one request to the shadow ring, return the response it should give
  function automatic ring_resp_t predict_ring_response(logic [2:0] act, logic [31:0] data);
    ring_resp_t r;
    int unsigned bk;
    r  = '0;
    bk = first_active ? 0 : 1;
    case (act)
      dbrb_pkg::ACT_PUSH: begin
        if (held == DEPTH) begin
          // full: oldest word is lost, head moves on
          head_idx = ring_advance(head_idx);
          full_overwrites++;
        end else begin
          held++;
        end
        shadow_bank[bk][tail_idx] = data;
        tail_idx = ring_advance(tail_idx);
        r.ok = 1'b1;
      end
      dbrb_pkg::ACT_POP, dbrb_pkg::ACT_PEEK: begin
        if (held != 0) begin
          r.read_data = shadow_bank[bk][head_idx];
          r.ok = 1'b1;
          if (act == dbrb_pkg::ACT_POP) begin
            head_idx = ring_advance(head_idx);
            held--;
          end
        end else begin
          empty_reads++;
        end
      end
      dbrb_pkg::ACT_SWAP: begin
        first_active = !first_active;
        head_idx = '0;
        tail_idx = '0;
        held     = 0;
        r.ok     = 1'b1;
        swaps_done++;
      end
      dbrb_pkg::ACT_CLEAR: begin
        head_idx = '0;
        tail_idx = '0;
        held     = 0;
        r.ok     = 1'b1;
      end
      dbrb_pkg::ACT_COPY: begin
        // pointers stay, so live entries now read the copied words
        for (int i = 0; i < DEPTH; i++) shadow_bank[bk][i] = shadow_bank[1 - bk][i];
        r.ok = 1'b1;
        copies_done++;
      end
      default: undefined_seen++;
    endcase
    r.fill_count     = 5'(held);
    r.is_empty       = (held == 0);
    r.is_full        = (held == DEPTH);
    r.primary_active = first_active;
    return r;
  endfunction

  function automatic ring_resp_t resp(logic [31:0] rd, bit ok, int unsigned cnt, bit prim);
    ring_resp_t r;
    r                = '0;
    r.read_data      = rd;
    r.ok             = ok;
    r.fill_count     = 5'(cnt);
    r.is_empty       = (cnt == 0);
    r.is_full        = (cnt == DEPTH);
    r.primary_active = prim;
    return r;
  endfunction

  function automatic stim_row_t row(logic [2:0] act, logic [31:0] data, int unsigned reps,
                                    bit typed, ring_resp_t want);
    stim_row_t s;
    s.act   = act;
    s.data  = data;
    s.reps  = reps;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(7))
      0:       w = '0;
      1:       w = '1;
      2:       w = 32'd1 << $urandom_range(31);
      3:       w = ~(32'd1 << $urandom_range(31));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // filling bursts push hard to reach the overwrite case, draining bursts empty the ring
  function automatic logic [2:0] pick_action(bit filling);
    int unsigned roll;
    logic [2:0]  a;
    roll = $urandom_range(99);
    if (filling) begin
      if      (roll < 62) a = dbrb_pkg::ACT_PUSH;
      else if (roll < 72) a = dbrb_pkg::ACT_POP;
      else if (roll < 82) a = dbrb_pkg::ACT_PEEK;
      else if (roll < 84) a = dbrb_pkg::ACT_SWAP;
      else if (roll < 85) a = dbrb_pkg::ACT_CLEAR;
      else if (roll < 96) a = dbrb_pkg::ACT_COPY;
      else                a = $urandom_range(1) ? ACT_RSVD_6 : ACT_RSVD_7;
    end else begin
      if      (roll < 20) a = dbrb_pkg::ACT_PUSH;
      else if (roll < 62) a = dbrb_pkg::ACT_POP;
      else if (roll < 78) a = dbrb_pkg::ACT_PEEK;
      else if (roll < 82) a = dbrb_pkg::ACT_SWAP;
      else if (roll < 85) a = dbrb_pkg::ACT_CLEAR;
      else if (roll < 95) a = dbrb_pkg::ACT_COPY;
      else                a = $urandom_range(1) ? ACT_RSVD_6 : ACT_RSVD_7;
    end
    return a;
  endfunction

  // drive one request from a falling edge, hold it until the block takes it
  task automatic send_request(input logic [2:0] act, input logic [31:0] data,
                              output ring_resp_t predicted);
    @(negedge clk_i);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tuser_i  <= 3'($urandom);
      s_axis_tdata_i  <= $urandom;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= data;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = predict_ring_response(act, data);
    requests_sent++;
  endtask

  task automatic report_mismatch(input string what, input ring_resp_t want,
                                 input ring_resp_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("tb: %s at %0t: want rd=%h ok=%b cnt=%0d e=%b f=%b p=%b pad=%h",
               what, $realtime, want.read_data, want.ok, want.fill_count, want.is_empty,
               want.is_full, want.primary_active, want.pad);
      $display("tb:   got rd=%h ok=%b cnt=%0d e=%b f=%b p=%b pad=%h",
               got.read_data, got.ok, got.fill_count, got.is_empty, got.is_full,
               got.primary_active, got.pad);
    end
  endtask

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk_i) begin
    m_axis_tready_i <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  // response checker, sampled on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_resp = m_axis_tdata_o;
      if (pending_responses.size() == 0) begin
        report_mismatch("response with nothing pending", '0, seen_resp);
      end else begin
        want_resp = pending_responses.pop_front();
        responses_checked++;
        if (seen_resp.read_data !== want_resp.read_data ||
            seen_resp.ok !== want_resp.ok ||
            seen_resp.fill_count !== want_resp.fill_count ||
            seen_resp.is_empty !== want_resp.is_empty ||
            seen_resp.is_full !== want_resp.is_full ||
            seen_resp.primary_active !== want_resp.primary_active ||
            seen_resp.pad !== want_resp.pad)
          report_mismatch("mismatch", want_resp, seen_resp);
      end
    end
  end

  initial begin
    ring_resp_t  predicted;
    logic [2:0]  act;
    bit          filling;
    int unsigned run_left;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    filling         = 1'b1;
    run_left        = 0;

    for (int b = 0; b < 2; b++)
      for (int i = 0; i < DEPTH; i++) shadow_bank[b][i] = '0;
    head_idx     = '0;
    tail_idx     = '0;
    held         = 0;
    first_active = 1'b1;

    // directed: empty reads, extremes, overwrite when full, undefined codes,
    // copy with live entries, both banks
    directed.push_back(row(dbrb_pkg::ACT_PEEK, 32'h0, 1, 1, resp(32'h0, 0, 0, 1)));
    directed.push_back(row(dbrb_pkg::ACT_POP, 32'h0, 1, 1, resp(32'h0, 0, 0, 1)));
    directed.push_back(row(dbrb_pkg::ACT_PUSH, 32'hFFFF_FFFF, 1, 1, resp(32'h0, 1, 1, 1)));
    directed.push_back(row(dbrb_pkg::ACT_PUSH, 32'h0, 1, 1, resp(32'h0, 1, 2, 1)));
    directed.push_back(row(dbrb_pkg::ACT_PEEK, 32'h0, 1, 1, resp(32'hFFFF_FFFF, 1, 2, 1)));
    directed.push_back(row(ACT_RSVD_6, 32'hDEAD_BEEF, 1, 1, resp(32'h0, 0, 2, 1)));
    directed.push_back(row(ACT_RSVD_7, 32'h0, 1, 1, resp(32'h0, 0, 2, 1)));
    directed.push_back(row(dbrb_pkg::ACT_PUSH, 32'h5555_AAAA, 14, 0, '0));
    directed.push_back(row(dbrb_pkg::ACT_PUSH, 32'hAAAA_5555, 1, 1,
                           resp(32'h0, 1, DEPTH, 1)));
    directed.push_back(row(dbrb_pkg::ACT_POP, 32'h0, 1, 1, resp(32'h0, 1, DEPTH - 1, 1)));
    directed.push_back(row(dbrb_pkg::ACT_PEEK, 32'h0, 1, 0, '0));
    // inactive bank still holds reset zeros
    directed.push_back(row(dbrb_pkg::ACT_COPY, 32'h0, 1, 1, resp(32'h0, 1, DEPTH - 1, 1)));
    directed.push_back(row(dbrb_pkg::ACT_PEEK, 32'h0, 1, 1, resp(32'h0, 1, DEPTH - 1, 1)));
    directed.push_back(row(dbrb_pkg::ACT_SWAP, 32'h0, 1, 1, resp(32'h0, 1, 0, 0)));
    directed.push_back(row(dbrb_pkg::ACT_PEEK, 32'h0, 1, 1, resp(32'h0, 0, 0, 0)));
    directed.push_back(row(dbrb_pkg::ACT_PUSH, 32'h1234_5678, 1, 0, '0));
    directed.push_back(row(dbrb_pkg::ACT_PUSH, 32'h9ABC_DEF0, 1, 0, '0));
    directed.push_back(row(ACT_RSVD_7, 32'h0, 1, 1, resp(32'h0, 0, 2, 0)));
    directed.push_back(row(dbrb_pkg::ACT_SWAP, 32'h0, 1, 1, resp(32'h0, 1, 0, 1)));
    directed.push_back(row(dbrb_pkg::ACT_PUSH, 32'h0000_0001, 1, 0, '0));
    directed.push_back(row(dbrb_pkg::ACT_COPY, 32'h0, 1, 0, '0));
    directed.push_back(row(dbrb_pkg::ACT_PEEK, 32'h0, 1, 0, '0));
    directed.push_back(row(dbrb_pkg::ACT_CLEAR, 32'h0, 1, 1, resp(32'h0, 1, 0, 1)));
    directed.push_back(row(dbrb_pkg::ACT_POP, 32'h0, 1, 1, resp(32'h0, 0, 0, 1)));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[r]) begin
      repeat (directed[r].reps) begin
        send_request(directed[r].act, directed[r].data, predicted);
        pending_responses.push_back(directed[r].typed ? directed[r].want : predicted);
      end
    end

    // random traffic: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      for (int n = 0; n < 232; n++) begin
        if (run_left == 0) begin
          filling  = !filling;
          run_left = $urandom_range(40, 12);
        end
        run_left--;
        act = pick_action(filling);
        send_request(act, pick_word(), predicted);
        pending_responses.push_back(predicted);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;

    while (pending_responses.size() != 0) @(posedge clk_i);
    // let any stray response show up
    repeat (2 * DEPTH + 8) @(posedge clk_i);

    $display("tb: %0d requests sent, %0d responses checked, %0d mismatches",
             requests_sent, responses_checked, mismatches);
    $display("tb: %0d overwrites when full, %0d empty pop/peek, %0d copies, %0d swaps,",
             full_overwrites, empty_reads, copies_done, swaps_done);
    $display("tb: %0d undefined actions", undefined_seen);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
